FILE: hdl/lfwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfwt_pkg: shared definitions for the Latin-1 folding word tokeniser
// Holds the character-class limits, the accent folding table and the record
// that the folding stage hands to the control logic.
// ----------------------------------------------------------------------------
package lfwt_pkg;

  // Default longest word plus one; words of this length or more are dropped.
  localparam int unsigned MaxWordLengthDef = 32;

  // Field widths fixed by the interface.
  localparam int unsigned CodePointW = 21;
  localparam int unsigned OffsetW    = 32;
  localparam int unsigned LetterW    = 7;
  localparam int unsigned LetterIdxW = 5;

  // Character-class limits.
  localparam logic [CodePointW-1:0] UpperFirst  = 21'h00041;
  localparam logic [CodePointW-1:0] UpperLast   = 21'h0005A;
  localparam logic [CodePointW-1:0] LowerFirst  = 21'h00061;
  localparam logic [CodePointW-1:0] LowerLast   = 21'h0007A;
  localparam logic [CodePointW-1:0] AccentFirst = 21'h000C0;
  localparam logic [CodePointW-1:0] AccentLast  = 21'h000FF;

  // ASCII code of 'a', the base of every emitted letter.
  localparam logic [LetterW-1:0] LetterBase = 7'h61;
  localparam logic [7:0]         AsciiLowA  = 8'h61;

  // Plain letter for each code point from 0xC0 to 0xFF, first entry leftmost.
  localparam logic [8*64-1:0] AccentFold =
      "aaaaaaeceeeeiiiidnoooooxouuuuypsaaaaaaeceeeeiiiionooooooouuuuypy";

  // Result of folding one code point.
  typedef struct packed {
    logic                  is_letter;
    logic [LetterIdxW-1:0] idx;
  } fold_t;

  // Letter index (0 for 'a') for an accented code point's low six bits.
  function automatic logic [LetterIdxW-1:0] accent_idx(input logic [5:0] sel);
    logic [7:0] ch;
    logic [7:0] diff;
    ch   = AccentFold[8*(63 - int'(sel)) +: 8];
    diff = ch - AsciiLowA;
    return diff[LetterIdxW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lfwt_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfwt_fold: code point classifier and folder
// Sorts a code point into letter or delimiter and gives the folded letter
// index for ASCII letters and the Latin-1 accented range.
// ----------------------------------------------------------------------------
module lfwt_fold
  import lfwt_pkg::*;
(
  input  var logic [CodePointW-1:0] code_point_i,
  output fold_t                     fold_o
);

  logic                  is_upper;
  logic                  is_lower;
  logic                  is_accent;
  logic [CodePointW-1:0] upper_diff;
  logic [CodePointW-1:0] lower_diff;

  // Range decode.
  assign is_upper  = (code_point_i >= UpperFirst)  && (code_point_i <= UpperLast);
  assign is_lower  = (code_point_i >= LowerFirst)  && (code_point_i <= LowerLast);
  assign is_accent = (code_point_i >= AccentFirst) && (code_point_i <= AccentLast);

  assign upper_diff = code_point_i - UpperFirst;
  assign lower_diff = code_point_i - LowerFirst;

  // Select the letter index; anything outside the three ranges is a delimiter.
  always_comb begin
    fold_o.is_letter = is_upper || is_lower || is_accent;
    if (is_upper) begin
      fold_o.idx = upper_diff[LetterIdxW-1:0];
    end else if (is_lower) begin
      fold_o.idx = lower_diff[LetterIdxW-1:0];
    end else if (is_accent) begin
      fold_o.idx = accent_idx(code_point_i[5:0]);
    end else begin
      fold_o.idx = '0;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/latin1_fold_word_tokenizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// latin1_fold_word_tokenizer_unit: word tokeniser with case and accent folding
// Buffers folded letters and plays each finished word out one letter a beat.
// ----------------------------------------------------------------------------
// A letter beat is taken and written to the word buffer. A
// delimiter or end-of-text beat that closes a word of n letters (1 to
// MAX_WORD_LENGTH-1) holds the input stalled while the sequencer reads
// the buffer one entry a cycle into the output register, as long as the
// output is free; any other beat is taken without a stall. A stall on the
// output side lengthens the play-out. Words of MAX_WORD_LENGTH letters or
// more are dropped without output. Each letter goes out with the word's
// start offset and a flag on its final letter. The buffer needs no clearing
// after reset: only entries already written for the current word are read.
module latin1_fold_word_tokenizer_unit
  import lfwt_pkg::*;
#(
  parameter int unsigned MAX_WORD_LENGTH = MaxWordLengthDef
) (
  input  var logic                  clk_i,
  input  var logic                  rst_ni,
  // Input channel
  input  var logic                  in_valid_i,
  output logic                      in_stall_o,
  input  var logic [CodePointW-1:0] code_point_i,
  input  var logic [OffsetW-1:0]    end_offset_i,
  input  var logic                  end_of_text_i,
  // Output channel
  output logic                      out_valid_o,
  input  var logic                  out_stall_i,
  output logic [LetterW-1:0]        letter_o,
  output logic [OffsetW-1:0]        word_start_offset_o,
  output logic                      last_letter_o
);

  localparam int unsigned Depth = MAX_WORD_LENGTH - 1;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LenW  = $clog2(MAX_WORD_LENGTH + 1);
  localparam logic [LenW-1:0] LenMax   = LenW'(MAX_WORD_LENGTH);
  localparam logic [LenW-1:0] LenDepth = LenW'(Depth);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [OffsetW-1:0]    start_q, start_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  eot_q, eot_d;
  logic                  out_valid_q, out_valid_d;
  logic [LetterW-1:0]    letter_q;
  logic [OffsetW-1:0]    out_start_q;
  logic                  last_q;
  logic [LetterIdxW-1:0] word_buf_q [Depth];

  fold_t                 fold;
  logic                  in_accept;
  logic                  out_free;
  logic                  emit_step;
  logic                  emit_last;
  logic                  word_ok;
  logic                  buf_wr;

  // Folding stage.
  lfwt_fold u_fold (
    .code_point_i (code_point_i),
    .fold_o       (fold)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_step  = (state_q == StEmit) && out_free;
  assign emit_last  = ((LenW'(rd_idx_q) + LenW'(1)) == len_q);
  assign word_ok    = (len_q != '0) && (len_q < LenMax);
  assign buf_wr     = in_accept && !end_of_text_i && fold.is_letter && (len_q < LenDepth);

  // Sequencer: collect letters, then play the word out one entry a cycle while the output is free.
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    start_d     = start_q;
    rd_idx_d    = rd_idx_q;
    eot_d       = eot_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (!end_of_text_i && fold.is_letter) begin
            if (len_q == '0) begin
              start_d = end_offset_i - OffsetW'(1);
            end
            if (len_q < LenMax) begin
              len_d = len_q + LenW'(1);
            end
          end else if (word_ok) begin
            state_d  = StEmit;
            rd_idx_d = '0;
            eot_d    = end_of_text_i;
          end else begin
            len_d = '0;
            if (end_of_text_i) begin
              start_d = '0;
            end
          end
        end
      end
      StEmit: begin
        if (emit_step) begin
          out_valid_d = 1'b1;
          rd_idx_d    = rd_idx_q + IdxW'(1);
          if (emit_last) begin
            state_d = StIdle;
            len_d   = '0;
            if (eot_q) begin
              start_d = '0;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      start_q     <= '0;
      rd_idx_q    <= '0;
      eot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      start_q     <= start_d;
      rd_idx_q    <= rd_idx_d;
      eot_q       <= eot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Word buffer and output payload: one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (buf_wr) begin
      word_buf_q[len_q[IdxW-1:0]] <= fold.idx;
    end
    if (emit_step) begin
      letter_q    <= LetterBase + LetterW'(word_buf_q[rd_idx_q]);
      out_start_q <= start_q;
      last_q      <= emit_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign letter_o            = letter_q;
  assign word_start_offset_o = out_start_q;
  assign last_letter_o       = last_q;

  // The length count never passes its saturation value.
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("word length count above saturation value");

  // Only a word of legal length is ever played out.
  a_emit_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (word_ok && (LenW'(rd_idx_q) < len_q)))
    else $error("play-out index or length out of range");

  // A new output beat appears only from the play-out sequence.
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StEmit))
    else $error("output beat without play-out");

  // Finishing a word returns to collecting with an empty count.
  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_step && emit_last) |=> ((state_q == StIdle) && (len_q == '0)))
    else $error("play-out did not close the word");

endmodule
`default_nettype wire

FILE: tb/sv/lfwt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfwt_tb_pkg: word scoreboard for the Latin-1 folding word tokeniser bench
// Keeps its own copy of the tokeniser state, predicts the letter beats that
// each accepted input beat releases and checks the output beats against them
// in order.
// ----------------------------------------------------------------------------
package lfwt_tb_pkg;
  import lfwt_pkg::*;

  // Distance from an upper-case ASCII letter to its lower-case form.
  localparam logic [7:0] CaseShift = 8'h20;
  // Fold result that marks a delimiter.
  localparam logic [7:0] NotALetter = 8'h00;

  // One beat on the input channel.
  typedef struct {
    logic [CodePointW-1:0] code_point;
    logic [OffsetW-1:0]    end_offset;
    logic                  end_of_text;
  } text_item_t;

  // One letter beat on the output channel.
  typedef struct {
    logic [LetterW-1:0] letter;
    logic [OffsetW-1:0] start;
    logic               last;
  } letter_beat_t;

  class word_scoreboard;
    string              accent_map =
        "aaaaaaeceeeeiiiidnoooooxouuuuypsaaaaaaeceeeeiiiionooooooouuuuypy";
    logic [LetterW-1:0] word_letters [$];
    int unsigned        letter_count;
    logic [OffsetW-1:0] start_offset;
    letter_beat_t       expected_letters [$];
    int unsigned        fail_count;

    function new();
      letter_count = 0;
      start_offset = '0;
      fail_count   = 0;
    endfunction

    // Folds a code point to its lower-case ASCII letter, or flags a delimiter.
    function logic [7:0] fold_code_point(input logic [CodePointW-1:0] cp);
      if (cp >= UpperFirst && cp <= UpperLast) return cp[7:0] + CaseShift;
      if (cp >= LowerFirst && cp <= LowerLast) return cp[7:0];
      if (cp >= AccentFirst && cp <= AccentLast) return accent_map[int'(cp[5:0])];
      return NotALetter;
    endfunction

    // Releases the buffered word if its length is legal, then empties it.
    function void flush_word();
      letter_beat_t beat;
      if (letter_count > 0 && letter_count < MaxWordLengthDef) begin
        foreach (word_letters[i]) begin
          beat.letter = word_letters[i];
          beat.start  = start_offset;
          beat.last   = (i == word_letters.size() - 1);
          expected_letters.insert(expected_letters.size(), beat);
        end
      end
      word_letters.delete();
      letter_count = 0;
    endfunction

    // Updates the word state for one accepted input beat.
    function void note_input(input logic [CodePointW-1:0] cp,
                             input logic [OffsetW-1:0] off, input logic eot);
      logic [7:0] folded;
      if (eot) begin
        flush_word();
        start_offset = '0;
        return;
      end
      folded = fold_code_point(cp);
      if (folded == NotALetter) begin
        flush_word();
        return;
      end
      if (letter_count == 0) start_offset = off - 1;
      // Letters past the buffer depth are only counted, and the count saturates.
      if (letter_count < MaxWordLengthDef - 1) begin
        word_letters.insert(word_letters.size(), folded[LetterW-1:0]);
      end
      if (letter_count < MaxWordLengthDef) letter_count++;
    endfunction

    // Compares one accepted output beat with the oldest predicted letter.
    function void check_result(input logic [LetterW-1:0] letter,
                               input logic [OffsetW-1:0] start, input logic last);
      letter_beat_t want;
      if (expected_letters.size() == 0) begin
        $display("%0t: unexpected letter beat: letter %h start %h last %b",
                 $time, letter, start, last);
        fail_count++;
        return;
      end
      want = expected_letters.pop_front();
      if (letter !== want.letter) begin
        $display("%0t: letter mismatch: expected %h, actual %h", $time, want.letter, letter);
        fail_count++;
      end
      if (start !== want.start) begin
        $display("%0t: word start mismatch: expected %h, actual %h", $time, want.start, start);
        fail_count++;
      end
      if (last !== want.last) begin
        $display("%0t: last letter mismatch: expected %b, actual %b", $time, want.last, last);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_letters.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_latin1_fold_word_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latin1_fold_word_tokenizer_unit: bench for the folding word tokeniser
// Sends a short directed text followed by random words, delimiters, text ends
// and noise in four phases of sender idling and receiver stalling, and checks
// every output beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_latin1_fold_word_tokenizer_unit;
  import lfwt_pkg::*;
  import lfwt_tb_pkg::*;

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned ResetCycles   = 4;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned ItemsPerPhase = 125;
  localparam int unsigned NumPhases     = 4;

  localparam logic [CodePointW-1:0] SpaceChar    = 21'h00020;
  localparam logic [CodePointW-1:0] TimesSign    = 21'h000D7;
  localparam logic [CodePointW-1:0] DivideSign   = 21'h000F7;
  localparam logic [CodePointW-1:0] MaxCodePoint = 21'h10FFFF;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [CodePointW-1:0] code_point_i  = '0;
  logic [OffsetW-1:0]    end_offset_i  = '0;
  logic                  end_of_text_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [LetterW-1:0]    letter_o;
  logic [OffsetW-1:0]    word_start_offset_o;
  logic                  last_letter_o;

  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    idle_cycles    = 0;
  logic [OffsetW-1:0] text_pos   = '0;
  text_item_t     text_beats [$];
  word_scoreboard scoreboard     = new();

  latin1_fold_word_tokenizer_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .code_point_i       (code_point_i),
    .end_offset_i       (end_offset_i),
    .end_of_text_i      (end_of_text_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .letter_o           (letter_o),
    .word_start_offset_o(word_start_offset_o),
    .last_letter_o      (last_letter_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Receiver: stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // Both channels are sampled at the edge; accepted beats go to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        scoreboard.note_input(code_point_i, end_offset_i, end_of_text_i);
      end
      if (out_valid_o && !out_stall_i) begin
        scoreboard.check_result(letter_o, word_start_offset_o, last_letter_o);
      end
    end
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [OffsetW-1:0] next_offset();
    text_pos = text_pos + OffsetW'($urandom_range(1, 4));
    return text_pos;
  endfunction

  function automatic void push_beat(input logic [CodePointW-1:0] cp,
                                    input logic [OffsetW-1:0] off, input logic eot);
    text_item_t beat;
    beat.code_point  = cp;
    beat.end_offset  = off;
    beat.end_of_text = eot;
    text_pos         = off;
    text_beats.insert(text_beats.size(), beat);
  endfunction

  function automatic logic [CodePointW-1:0] random_letter_cp();
    case ($urandom_range(2))
      0:       return CodePointW'($urandom_range(UpperFirst, UpperLast));
      1:       return CodePointW'($urandom_range(LowerFirst, LowerLast));
      default: return CodePointW'($urandom_range(AccentFirst, AccentLast));
    endcase
  endfunction

  // Delimiters from every gap between the letter ranges and far beyond them.
  function automatic logic [CodePointW-1:0] random_delimiter_cp();
    case ($urandom_range(5))
      0:       return SpaceChar;
      1:       return CodePointW'($urandom_range(0, UpperFirst - 1));
      2:       return CodePointW'($urandom_range(UpperLast + 1, LowerFirst - 1));
      3:       return CodePointW'($urandom_range(LowerLast + 1, AccentFirst - 1));
      4:       return CodePointW'($urandom_range(AccentLast + 1, MaxCodePoint));
      default: return CodePointW'($urandom_range(MaxCodePoint + 1, {CodePointW{1'b1}}));
    endcase
  endfunction

  // A well-formed word of random content, mostly short, now and then near or past the length limit.
  function automatic void push_random_word();
    int unsigned        len;
    logic [OffsetW-1:0] first_off;
    if ($urandom_range(99) < 8) begin
      len = $urandom_range(MaxWordLengthDef - 2, MaxWordLengthDef + 8);
    end else begin
      len = $urandom_range(1, 8);
    end
    case ($urandom_range(19))
      0:       first_off = '0;
      1:       first_off = $urandom();
      default: first_off = next_offset();
    endcase
    push_beat(random_letter_cp(), first_off, 1'b0);
    for (int unsigned n = 1; n < len; n++) begin
      push_beat(random_letter_cp(), next_offset(), 1'b0);
    end
    case ($urandom_range(19))
      0, 1: begin
        push_beat(CodePointW'($urandom()), $urandom(), 1'b1);
        text_pos = ($urandom_range(1) == 0) ? '0 : OffsetW'($urandom());
      end
      2: ; // the next word runs straight on
      3: begin
        push_beat(random_delimiter_cp(), next_offset(), 1'b0);
        push_beat(random_delimiter_cp(), next_offset(), 1'b0);
      end
      default: push_beat(random_delimiter_cp(), next_offset(), 1'b0);
    endcase
  endfunction

  // Presents one beat after a random gap and holds it until it is taken.
  task automatic drive_item(input text_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    code_point_i  <= beat.code_point;
    end_offset_i  <= beat.end_offset;
    end_of_text_i <= beat.end_of_text;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    int unsigned send_rates [NumPhases] = '{0, 79, 0, 23};
    int unsigned stall_rates[NumPhases] = '{0, 0, 79, 23};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = send_rates[p];
      recv_stall_pct = stall_rates[p];
      text_beats.delete();
      if (p == 0) begin
        // Upper-case limits, with the first word at offset zero so its start wraps.
        push_beat(UpperFirst, '0, 1'b0);
        push_beat(CodePointW'(UpperFirst - 1), next_offset(), 1'b0);
        push_beat(UpperLast, next_offset(), 1'b0);
        push_beat(CodePointW'(UpperLast + 1), next_offset(), 1'b0);
        // Lower-case limits.
        push_beat(LowerFirst, next_offset(), 1'b0);
        push_beat(LowerLast, next_offset(), 1'b0);
        push_beat(CodePointW'(LowerLast + 1), next_offset(), 1'b0);
        // Accent range ends and the multiplication and division signs.
        push_beat(AccentFirst, next_offset(), 1'b0);
        push_beat(TimesSign, next_offset(), 1'b0);
        push_beat(DivideSign, next_offset(), 1'b0);
        push_beat(AccentLast, next_offset(), 1'b0);
        push_beat(CodePointW'(AccentFirst - 1), next_offset(), 1'b0);
        // A delimiter with no word before it.
        push_beat(CodePointW'(LowerFirst - 1), next_offset(), 1'b0);
        // Code points above the Unicode range act as delimiters.
        push_beat(UpperFirst, next_offset(), 1'b0);
        push_beat(CodePointW'(MaxCodePoint + 1), next_offset(), 1'b0);
        push_beat(LowerFirst, next_offset(), 1'b0);
        push_beat({CodePointW{1'b1}}, next_offset(), 1'b0);
        // End of text flushes a pending word, and then finds nothing to flush.
        push_beat(CodePointW'(LowerFirst + 16), next_offset(), 1'b0);
        push_beat(CodePointW'(UpperFirst + 17), next_offset(), 1'b0);
        push_beat(UpperFirst, next_offset(), 1'b1);
        push_beat(UpperFirst, next_offset(), 1'b1);
        // Highest offset.
        push_beat(LowerLast, '1, 1'b0);
        push_beat('0, '1, 1'b1);
      end
      while (text_beats.size() < ItemsPerPhase) begin
        if ($urandom_range(9) == 0) begin
          push_beat(CodePointW'($urandom()), $urandom(), 1'($urandom_range(1)));
        end else begin
          push_random_word();
        end
      end
      foreach (text_beats[i]) drive_item(text_beats[i]);
    end
    in_valid_i <= 1'b0;

    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (scoreboard.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
